>>> rtl/mfsd_pkg.sv
`timescale 1ns / 1ps

package mfsd_pkg;

   localparam int BUF_BYTES_DEF   = 64;
   localparam int HDR_BYTES       = 8;
   localparam int HDR_IDX_W       = $clog2(HDR_BYTES);
   localparam int LEN_BYTES       = 4;
   localparam int HDR_TYPE_POS    = 2;
   localparam int HDR_ID_POS      = 3;
   localparam int HDR_LEN_POS     = HDR_BYTES - LEN_BYTES;
   localparam int BYTE_W          = 8;
   localparam int LEN_W           = 6;
   localparam int TALLY_W         = 16;
   localparam int CSR_IDX_W       = 2;

   localparam logic [LEN_W-1:0]     MAX_PAYLOAD_RST = 6'd56;
   localparam logic [TALLY_W-1:0]   TALLY_MAX       = 16'hFFFF;

   localparam logic [CSR_IDX_W-1:0] REG_MAGIC_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAGIC_SECOND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_PAYLOAD  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_PARSE,
      ST_HDR,
      ST_CHECK,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_EMIT_EMPTY,
      ST_FRAME_DROP,
      ST_RESYNC,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic push;
      logic drop;
      logic clear;
   } ring_ctl_type;

endpackage

>>> rtl/magic_framed_stream_deframer_unit.sv
`timescale 1ns / 1ps

// Length-prefixed frame deframer. Received bytes are taken one beat at a time
// into a circular buffer of BUF_BYTES bytes held in one synchronous RAM with a
// single read port; removing a frame or resyncing only moves the head pointer and fill count.
// Each frame is 8 header bytes (two magic bytes, type, id, 32-bit little-endian
// length) and its payload; a complete frame leaves as one result beat per
// payload byte (or one empty marker) and is then removed. A bad header makes
// the block scan the buffer for the magic pair from offset 1; an oversized
// length also bumps a saturating counter. Each input byte is accepted in ST_IDLE
// and stored in ST_WRITE; each parse attempt then reads and checks the header,
// each delivered payload byte is read and then loaded (held while rsp_ready is
// low), and a resync scans the buffer, all paced by the one RAM read port.
// No clearing pass follows reset: req_ready is high as soon as reset ends.
module magic_framed_stream_deframer_unit import mfsd_pkg::*; #(
   parameter int BUF_BYTES = BUF_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [BYTE_W-1:0]    rsp_frame_type,
   output logic [BYTE_W-1:0]    rsp_frame_id,
   output logic [LEN_W-1:0]     rsp_payload_length,
   output logic [BYTE_W-1:0]    rsp_payload_byte,
   output logic                 rsp_byte_present,
   output logic                 rsp_frame_end,
   output logic [TALLY_W-1:0]   rsp_oversized_count,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata
);

   localparam int FILL_W = $clog2(BUF_BYTES + 1);
   localparam int CNT_W  = (FILL_W > 7) ? FILL_W : 7;

   state_type           state_ff, state_in;
   ring_ctl_type        ring_ctl;
   logic [FILL_W-1:0]   drop_n, rd_off, fill;
   logic [BYTE_W-1:0]   rd_data;

   logic [BYTE_W-1:0]   magic_first_ff, magic_second_ff;
   logic [LEN_W-1:0]    max_payload_ff;

   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic [FILL_W-1:0]   off_ff, off_in;
   logic [LEN_W-1:0]    k_ff, k_in;
   logic [BYTE_W-1:0]   prev_ff, prev_in;
   logic                pre_ff, pre_in;
   logic                init_rs_ff, init_rs_in;
   logic [TALLY_W-1:0]  tally_ff, tally_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [FILL_W-1:0]   rd_off_ff;
   logic                issue;
   logic [BYTE_W-1:0]   hdr_ff [HDR_BYTES];
   logic [BYTE_W-1:0]   hdr_in [HDR_BYTES];

   logic                out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]   out_type_ff, out_type_in;
   logic [BYTE_W-1:0]   out_id_ff, out_id_in;
   logic [LEN_W-1:0]    out_len_ff, out_len_in;
   logic [BYTE_W-1:0]   out_byte_ff, out_byte_in;
   logic                out_present_ff, out_present_in;
   logic                out_end_ff, out_end_in;
   logic [TALLY_W-1:0]  out_count_ff, out_count_in;
   logic                load;
   logic                out_free;

   logic [LEN_W-1:0]    len6;
   logic                len_too_big;
   logic [CNT_W-1:0]    total_w;
   logic [CNT_W-1:0]    pay_off_w;
   logic                magic_ok;

   mfsd_ring #(.BUF_BYTES(BUF_BYTES)) u_ring (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ring_ctl),
      .wr_data (byte_ff),
      .drop_n  (drop_n),
      .rd_off  (rd_off),
      .rd_data (rd_data),
      .fill    (fill)
   );

   assign len6        = hdr_ff[HDR_LEN_POS][LEN_W-1:0];
   assign len_too_big = (|hdr_ff[HDR_LEN_POS+1]) || (|hdr_ff[HDR_LEN_POS+2]) ||
                        (|hdr_ff[HDR_LEN_POS+3]) ||
                        (|hdr_ff[HDR_LEN_POS][BYTE_W-1:LEN_W]) || (len6 > max_payload_ff);
   assign total_w     = CNT_W'(HDR_BYTES) + CNT_W'(len6);
   assign pay_off_w   = CNT_W'(HDR_BYTES) + CNT_W'(k_ff);
   assign magic_ok    = (hdr_ff[0] == magic_first_ff) && (hdr_ff[1] == magic_second_ff);
   assign out_free    = !out_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      byte_in        = byte_ff;
      off_in         = off_ff;
      k_in           = k_ff;
      prev_in        = prev_ff;
      pre_in         = pre_ff;
      init_rs_in     = init_rs_ff;
      tally_in       = tally_ff;
      hdr_in         = hdr_ff;
      ring_ctl       = '0;
      drop_n         = '0;
      rd_off         = off_ff;
      issue          = 1'b0;
      load           = 1'b0;
      out_type_in    = out_type_ff;
      out_id_in      = out_id_ff;
      out_len_in     = out_len_ff;
      out_byte_in    = out_byte_ff;
      out_present_in = out_present_ff;
      out_end_in     = out_end_ff;
      out_count_in   = out_count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               byte_in = req_rx_byte;
               if (fill == FILL_W'(BUF_BYTES)) begin
                  // full: resync and parse before the new byte goes in
                  pre_in     = 1'b1;
                  init_rs_in = 1'b1;
                  state_in   = ST_RESYNC;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            ring_ctl.push = 1'b1;
            state_in      = ST_PARSE;
         end
         ST_PARSE: begin
            if (fill < FILL_W'(HDR_BYTES)) begin
               pre_in   = 1'b0;
               state_in = pre_ff ? ST_WRITE : ST_IDLE;
            end else begin
               off_in   = '0;
               state_in = ST_HDR;
            end
         end
         ST_HDR: begin
            if (off_ff < FILL_W'(HDR_BYTES)) begin
               issue  = 1'b1;
               off_in = off_ff + FILL_W'(1);
            end
            if (rd_vld_ff) begin
               hdr_in[rd_off_ff[HDR_IDX_W-1:0]] = rd_data;
               if (rd_off_ff == FILL_W'(HDR_BYTES - 1)) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (!magic_ok) begin
               state_in = ST_RESYNC;
            end else if (len_too_big || (total_w > CNT_W'(BUF_BYTES))) begin
               if (tally_ff != TALLY_MAX) begin
                  tally_in = tally_ff + TALLY_W'(1);
               end
               state_in = ST_RESYNC;
            end else if (CNT_W'(fill) < total_w) begin
               pre_in   = 1'b0;
               state_in = pre_ff ? ST_WRITE : ST_IDLE;
            end else if (len6 == '0) begin
               state_in = ST_EMIT_EMPTY;
            end else begin
               k_in     = '0;
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            rd_off   = pay_off_w[FILL_W-1:0];
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            rd_off = pay_off_w[FILL_W-1:0];
            if (out_free) begin
               load           = 1'b1;
               out_type_in    = hdr_ff[HDR_TYPE_POS];
               out_id_in      = hdr_ff[HDR_ID_POS];
               out_len_in     = len6;
               out_byte_in    = rd_data;
               out_present_in = 1'b1;
               out_end_in     = (k_ff == len6 - LEN_W'(1));
               out_count_in   = tally_ff;
               k_in           = k_ff + LEN_W'(1);
               state_in       = (k_ff == len6 - LEN_W'(1)) ? ST_FRAME_DROP : ST_EMIT_RD;
            end
         end
         ST_EMIT_EMPTY: begin
            if (out_free) begin
               load           = 1'b1;
               out_type_in    = hdr_ff[HDR_TYPE_POS];
               out_id_in      = hdr_ff[HDR_ID_POS];
               out_len_in     = '0;
               out_byte_in    = '0;
               out_present_in = 1'b0;
               out_end_in     = 1'b1;
               out_count_in   = tally_ff;
               state_in       = ST_FRAME_DROP;
            end
         end
         ST_FRAME_DROP: begin
            ring_ctl.drop = 1'b1;
            drop_n        = total_w[FILL_W-1:0];
            state_in      = ST_PARSE;
         end
         ST_RESYNC: begin
            if (fill < FILL_W'(2)) begin
               ring_ctl.clear = 1'b1;
               init_rs_in     = 1'b0;
               pre_in         = pre_ff && init_rs_ff;
               state_in       = init_rs_ff ? ST_PARSE : (pre_ff ? ST_WRITE : ST_IDLE);
            end else begin
               off_in   = FILL_W'(1);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (off_ff < fill) begin
               issue  = 1'b1;
               off_in = off_ff + FILL_W'(1);
            end
            if (rd_vld_ff) begin
               prev_in = rd_data;
               if ((rd_off_ff >= FILL_W'(2)) && (prev_ff == magic_first_ff) &&
                   (rd_data == magic_second_ff)) begin
                  // drop everything before the pair
                  ring_ctl.drop = 1'b1;
                  drop_n        = rd_off_ff - FILL_W'(1);
                  init_rs_in    = 1'b0;
                  pre_in        = pre_ff && init_rs_ff;
                  state_in      = init_rs_ff ? ST_PARSE : (pre_ff ? ST_WRITE : ST_IDLE);
               end else if (rd_off_ff == fill - FILL_W'(1)) begin
                  ring_ctl.clear = 1'b1;
                  init_rs_in     = 1'b0;
                  pre_in         = pre_ff && init_rs_ff;
                  state_in       = init_rs_ff ? ST_PARSE : (pre_ff ? ST_WRITE : ST_IDLE);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rd_vld_in    = issue;
      out_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         pre_ff          <= 1'b0;
         init_rs_ff      <= 1'b0;
         tally_ff        <= '0;
         rd_vld_ff       <= 1'b0;
         out_valid_ff    <= 1'b0;
         magic_first_ff  <= '0;
         magic_second_ff <= '0;
         max_payload_ff  <= MAX_PAYLOAD_RST;
      end else begin
         state_ff     <= state_in;
         pre_ff       <= pre_in;
         init_rs_ff   <= init_rs_in;
         tally_ff     <= tally_in;
         rd_vld_ff    <= rd_vld_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_MAGIC_FIRST:  magic_first_ff  <= csr_wdata;
               REG_MAGIC_SECOND: magic_second_ff <= csr_wdata;
               REG_MAX_PAYLOAD:  max_payload_ff  <= csr_wdata[LEN_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff        <= byte_in;
      off_ff         <= off_in;
      k_ff           <= k_in;
      prev_ff        <= prev_in;
      rd_off_ff      <= rd_off;
      hdr_ff         <= hdr_in;
      out_type_ff    <= out_type_in;
      out_id_ff      <= out_id_in;
      out_len_ff     <= out_len_in;
      out_byte_ff    <= out_byte_in;
      out_present_ff <= out_present_in;
      out_end_ff     <= out_end_in;
      out_count_ff   <= out_count_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_frame_type      = out_type_ff;
   assign rsp_frame_id        = out_id_ff;
   assign rsp_payload_length  = out_len_ff;
   assign rsp_payload_byte    = out_byte_ff;
   assign rsp_byte_present    = out_present_ff;
   assign rsp_frame_end       = out_end_ff;
   assign rsp_oversized_count = out_count_ff;

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill <= FILL_W'(BUF_BYTES))
      else $error("buffer fill beyond capacity");

   a_tally_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> tally_ff >= $past(tally_ff))
      else $error("oversize counter went backward");

   a_load_has_header: assert property (@(posedge clock) disable iff (reset)
      load |-> fill >= FILL_W'(HDR_BYTES))
      else $error("result beat loaded without a full header in the buffer");

   a_marker_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_present) |-> (rsp_frame_end && rsp_payload_length == '0))
      else $error("empty marker not flagged as frame end");

endmodule

>>> rtl/mfsd_ring.sv
`timescale 1ns / 1ps

module mfsd_ring import mfsd_pkg::*; #(
   parameter int BUF_BYTES = BUF_BYTES_DEF,
   localparam int ADDR_W = $clog2(BUF_BYTES),
   localparam int FILL_W = $clog2(BUF_BYTES + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  ring_ctl_type      ctl,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic [FILL_W-1:0] drop_n,
   input  logic [FILL_W-1:0] rd_off,
   output logic [BYTE_W-1:0] rd_data,
   output logic [FILL_W-1:0] fill
);

   localparam int SUM_W = $clog2(2 * BUF_BYTES);

   logic [BYTE_W-1:0] mem [BUF_BYTES];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [ADDR_W-1:0] wr_addr, rd_addr;

   // offset from the head, folded back into the buffer
   function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                  input logic [FILL_W-1:0] off);
      logic [SUM_W-1:0] s;
      logic [SUM_W-1:0] d;
      s = SUM_W'(base) + SUM_W'(off);
      d = s - SUM_W'(BUF_BYTES);
      return (s >= SUM_W'(BUF_BYTES)) ? d[ADDR_W-1:0] : s[ADDR_W-1:0];
   endfunction

   assign wr_addr = wrap_add(head_ff, fill_ff);
   assign rd_addr = wrap_add(head_ff, rd_off);

   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      if (ctl.clear) begin
         fill_in = '0;
      end else if (ctl.drop) begin
         if (drop_n >= fill_ff) begin
            fill_in = '0;
         end else begin
            head_in = wrap_add(head_ff, drop_n);
            fill_in = fill_ff - drop_n;
         end
      end else if (ctl.push) begin
         fill_in = fill_ff + FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign fill    = fill_ff;

endmodule

>>> bench/tb_magic_framed_stream_deframer_unit.sv
`timescale 1ns / 1ps

module tb_magic_framed_stream_deframer_unit import mfsd_pkg::*; ();

   localparam int BUF_DEPTH     = BUF_BYTES_DEF;
   localparam int SETTLE_CYCLES = 300;
   localparam int QUIET_LIMIT   = 3000;
   localparam int REPORT_MAX    = 10;

   // index with no register behind it
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;

   typedef struct {
      logic [BYTE_W-1:0]  ftype;
      logic [BYTE_W-1:0]  fid;
      logic [LEN_W-1:0]   plen;
      logic [BYTE_W-1:0]  pbyte;
      logic               present;
      logic               last;
      logic [TALLY_W-1:0] tally;
   } frame_beat_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [BYTE_W-1:0]    req_rx_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [BYTE_W-1:0]    rsp_frame_type;
   logic [BYTE_W-1:0]    rsp_frame_id;
   logic [LEN_W-1:0]     rsp_payload_length;
   logic [BYTE_W-1:0]    rsp_payload_byte;
   logic                 rsp_byte_present;
   logic                 rsp_frame_end;
   logic [TALLY_W-1:0]   rsp_oversized_count;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [BYTE_W-1:0]    csr_wdata = '0;

   magic_framed_stream_deframer_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_frame_type      (rsp_frame_type),
      .rsp_frame_id        (rsp_frame_id),
      .rsp_payload_length  (rsp_payload_length),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_byte_present    (rsp_byte_present),
      .rsp_frame_end       (rsp_frame_end),
      .rsp_oversized_count (rsp_oversized_count),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // deframer mirror: buffer, tally and register shadows
   logic [BYTE_W-1:0]  mirror_buf [BUF_DEPTH];
   int unsigned        mirror_fill = 0;
   logic [TALLY_W-1:0] mirror_tally = '0;
   logic [BYTE_W-1:0]  cfg_magic0 = '0;
   logic [BYTE_W-1:0]  cfg_magic1 = '0;
   logic [LEN_W-1:0]   cfg_max_len = MAX_PAYLOAD_RST;

   frame_beat_type beats_due[$];
   frame_beat_type want;

   int fault_count   = 0;
   int beats_checked = 0;
   int frames_seen   = 0;
   int resync_seen   = 0;
   int bytes_in      = 0;
   int csr_writes    = 0;
   int burst_left    = 0;
   int quiet_cycles  = 0;
   bit sender_steady = 1'b0;

   logic [31:0] stall_pat = '0;
   int          stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void shift_out(int unsigned n);
      int unsigned i;
      if (n >= mirror_fill) begin
         mirror_fill = 0;
         return;
      end
      for (i = 0; i < mirror_fill - n; i++)
         mirror_buf[i] = mirror_buf[i + n];
      mirror_fill -= n;
   endfunction

   function automatic void hunt_magic();
      int unsigned i;
      resync_seen++;
      if (mirror_fill < 2) begin
         mirror_fill = 0;
         return;
      end
      for (i = 1; i + 1 < mirror_fill; i++) begin
         if (mirror_buf[i] == cfg_magic0 && mirror_buf[i + 1] == cfg_magic1) begin
            shift_out(i);
            return;
         end
      end
      mirror_fill = 0;
   endfunction

   // One parse attempt; true when a whole frame was emitted and removed.
   function automatic bit take_frame();
      logic [31:0] len;
      int unsigned total;
      int unsigned k;
      frame_beat_type beat;
      if (mirror_fill < HDR_BYTES)
         return 1'b0;
      if (mirror_buf[0] != cfg_magic0 || mirror_buf[1] != cfg_magic1) begin
         hunt_magic();
         return 1'b0;
      end
      len = {mirror_buf[HDR_LEN_POS + 3], mirror_buf[HDR_LEN_POS + 2],
             mirror_buf[HDR_LEN_POS + 1], mirror_buf[HDR_LEN_POS]};
      if (len > cfg_max_len || len + HDR_BYTES > BUF_DEPTH) begin
         if (mirror_tally != TALLY_MAX)
            mirror_tally++;
         hunt_magic();
         return 1'b0;
      end
      total = HDR_BYTES + len;
      if (mirror_fill < total)
         return 1'b0;
      beat.ftype = mirror_buf[HDR_TYPE_POS];
      beat.fid   = mirror_buf[HDR_ID_POS];
      beat.plen  = len[LEN_W-1:0];
      beat.tally = mirror_tally;
      if (len == 0) begin
         beat.pbyte   = '0;
         beat.present = 1'b0;
         beat.last    = 1'b1;
         beats_due.push_back(beat);
      end else begin
         for (k = 0; k < len; k++) begin
            beat.pbyte   = mirror_buf[HDR_BYTES + k];
            beat.present = 1'b1;
            beat.last    = (k + 1 == len);
            beats_due.push_back(beat);
         end
      end
      frames_seen++;
      shift_out(total);
      return 1'b1;
   endfunction

   function automatic void absorb_byte(logic [BYTE_W-1:0] b);
      if (mirror_fill >= BUF_DEPTH) begin
         hunt_magic();
         if (mirror_fill >= BUF_DEPTH)
            shift_out(1);
         while (take_frame()) begin
         end
      end
      if (mirror_fill < BUF_DEPTH) begin
         mirror_buf[mirror_fill] = b;
         mirror_fill++;
      end
      while (take_frame()) begin
      end
   endfunction

   function automatic int unsigned pick_len();
      int unsigned cap;
      cap = cfg_max_len;
      // mostly short frames, a few up to the limit
      if (cap > 8 && $urandom_range(0, 9) < 8)
         cap = 8;
      return $urandom_range(0, cap);
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if (burst_left == 0) begin
         if (!sender_steady) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      absorb_byte(b);
      bytes_in++;
      burst_left--;
   endtask

   task automatic send_frame(input logic [BYTE_W-1:0] m0, m1, ftype, fid,
                             input logic [31:0] len, input int body);
      int k;
      send_byte(m0);
      send_byte(m1);
      send_byte(ftype);
      send_byte(fid);
      for (k = 0; k < LEN_BYTES; k++)
         send_byte(len[8*k +: 8]);
      for (k = 0; k < body; k++)
         send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic hold_until_drained();
      req_valid  <= 1'b0;
      burst_left = 0;
      while (beats_due.size() != 0) @(posedge clock);
   endtask

   // drain, then give the block time to finish any scan still running
   task automatic quiesce();
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         REG_MAGIC_FIRST:  cfg_magic0 = data;
         REG_MAGIC_SECOND: cfg_magic1 = data;
         REG_MAX_PAYLOAD:  cfg_max_len = data[LEN_W-1:0];
         default: ;
      endcase
      csr_writes++;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [BYTE_W-1:0] m0, m1, max_w);
      quiesce();
      write_reg(REG_MAGIC_FIRST, m0);
      write_reg(REG_MAGIC_SECOND, m1);
      write_reg(REG_MAX_PAYLOAD, max_w);
   endtask

   // Well-formed frames with random content, plus oversize, broken,
   // truncated and noise sequences.
   task automatic run_traffic(input int budget, input bit steady, input bit pause_midway);
      int          start;
      int          r;
      bit          paused;
      logic [7:0]  m0;
      logic [7:0]  m1;
      logic [31:0] len;
      start  = bytes_in;
      paused = 1'b0;
      sender_steady = steady;
      while (bytes_in - start < budget) begin
         if (pause_midway && !paused && bytes_in - start >= budget / 2) begin
            hold_until_drained();
            paused = 1'b1;
         end
         r = $urandom_range(0, 99);
         if (r < 65) begin
            len = pick_len();
            send_frame(cfg_magic0, cfg_magic1, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), len, len);
         end else if (r < 75) begin
            if (cfg_max_len > 56 && $urandom_range(0, 1) == 1)
               len = $urandom_range(57, cfg_max_len);
            else if ($urandom_range(0, 1) == 1)
               len = cfg_max_len + 1 + $urandom_range(0, 3);
            else
               len = $urandom | 32'h0000_0040;
            send_frame(cfg_magic0, cfg_magic1, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), len, $urandom_range(0, 4));
         end else if (r < 85) begin
            m0 = cfg_magic0;
            m1 = cfg_magic1;
            if ($urandom_range(0, 1) == 1)
               m0 = m0 ^ (8'h01 << $urandom_range(0, 7));
            else
               m1 = m1 ^ (8'h01 << $urandom_range(0, 7));
            len = pick_len();
            send_frame(m0, m1, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), len, len);
         end else if (r < 92) begin
            send_byte(cfg_magic0);
            send_byte(cfg_magic1);
            repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
         end
      end
      sender_steady = 1'b0;
   endtask

   task automatic test_empty_frame_default();
      send_frame(8'h00, 8'h00, 8'hFF, 8'h00, 32'd0, 0);
   endtask

   task automatic test_single_byte_frame();
      apply_settings(8'hA5, 8'h5A, 8'd56);
      send_frame(8'hA5, 8'h5A, 8'h00, 8'hFF, 32'd1, 0);
      send_byte(8'hFF);
   endtask

   task automatic test_resync_and_oversize();
      // stray byte ahead of the header, then a length far over the limit
      send_byte(8'h3C);
      send_frame(8'hA5, 8'h5A, 8'h01, 8'h02, 32'hFFFF_FFFF, 0);
   endtask

   task automatic test_mixed_traffic();
      run_traffic(45, 1'b0, 1'b0);
   endtask

   task automatic test_zero_max_payload();
      // upper data bits fall outside the 6-bit register
      apply_settings(8'h00, 8'hFF, 8'hC0);
      run_traffic(30, 1'b1, 1'b0);
   endtask

   task automatic test_buffer_fit_limit();
      apply_settings(8'hFF, 8'hFF, 8'hFF);
      run_traffic(45, 1'b0, 1'b1);
   endtask

   task automatic test_random_settings();
      apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(1, 56)));
      write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
      run_traffic(40, 1'b0, 1'b0);
   endtask

   task automatic test_short_frames();
      apply_settings(8'h7E, 8'h81, 8'd8);
      run_traffic(35, 1'b0, 1'b0);
   endtask

   // receiver stall pattern, reloaded whenever stall_left runs out
   always @(posedge clock) begin
      if (stall_left == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pat = '0;
            1: stall_pat = $urandom;
            2: stall_pat = $urandom & $urandom;
            default: stall_pat = $urandom | $urandom;
         endcase
         stall_left = 32;
      end
      rsp_ready <= ~stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[31:1]};
      stall_left--;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         beats_checked++;
         if (beats_due.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_MAX)
               $display("%0t: unexpected beat type=%02h id=%02h byte=%02h end=%0b",
                        $realtime, rsp_frame_type, rsp_frame_id, rsp_payload_byte,
                        rsp_frame_end);
         end else begin
            want = beats_due.pop_front();
            if (rsp_frame_type !== want.ftype || rsp_frame_id !== want.fid ||
                rsp_payload_length !== want.plen || rsp_payload_byte !== want.pbyte ||
                rsp_byte_present !== want.present || rsp_frame_end !== want.last ||
                rsp_oversized_count !== want.tally) begin
               fault_count++;
               if (fault_count <= REPORT_MAX) begin
                  $display("%0t: beat mismatch", $realtime);
                  $display("  exp type=%02h id=%02h len=%0d byte=%02h pres=%0b end=%0b ovs=%0d",
                           want.ftype, want.fid, want.plen, want.pbyte, want.present,
                           want.last, want.tally);
                  $display("  got type=%02h id=%02h len=%0d byte=%02h pres=%0b end=%0b ovs=%0d",
                           rsp_frame_type, rsp_frame_id, rsp_payload_length,
                           rsp_payload_byte, rsp_byte_present, rsp_frame_end,
                           rsp_oversized_count);
               end
            end
         end
      end
   end

   // watchdog: any beat or register write counts as progress
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_frame_default();
      test_single_byte_frame();
      test_resync_and_oversize();
      test_mixed_traffic();
      test_zero_max_payload();
      test_buffer_fit_limit();
      test_random_settings();
      test_short_frames();
      quiesce();
      fault_count += beats_due.size();
      $display("Sent %0d bytes; checked %0d beats from %0d frames; %0d resyncs, %0d oversized.",
               bytes_in, beats_checked, frames_seen, resync_seen, mirror_tally);
      $display("Made %0d register writes, magic pairs 00/00 to FF/FF, max payload 0 to 63.",
               csr_writes);
      if (fault_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
